[design/c3v_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3v_pkg
// Shared types, widths and register codes of the 3x3 valid-region
// convolution stream.
// ----------------------------------------------------------------------------
package c3v_pkg;

   localparam int MAX_WIDTH   = 64;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int WCMP_W      = COL_W + 1;
   localparam int WREG_W      = 7;
   localparam int EXT_W       = (WCMP_W > WREG_W) ? WCMP_W : WREG_W;
   localparam int ROW_W       = 10;
   localparam int OUT_COL_W   = 6;
   localparam int PIX_W       = 16;
   localparam int WGT_W       = 16;
   localparam int KROW_W      = 3 * WGT_W;
   localparam int PROD_W      = PIX_W + WGT_W;
   localparam int ACC_W       = 36;
   localparam int LINE_W      = 2 * PIX_W;
   localparam int CSR_IDX_W   = 3;
   localparam int RSP_FIELD_W = ACC_W + ROW_W + OUT_COL_W;
   localparam int RSP_DATA_W  = ((RSP_FIELD_W + 7) / 8) * 8;

   localparam logic [WREG_W-1:0] WIDTH_RESET  = WREG_W'(64);
   localparam logic [ROW_W-1:0]  HEIGHT_RESET = ROW_W'(64);
   localparam int                MIN_SIZE     = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_KERNEL_TOP    = 3'd0,
      REG_KERNEL_MIDDLE = 3'd1,
      REG_KERNEL_BOTTOM = 3'd2,
      REG_IMAGE_WIDTH   = 3'd3,
      REG_IMAGE_HEIGHT  = 3'd4
   } reg_index_type;

   typedef logic signed [PIX_W-1:0] pix_type;
   typedef pix_type [2:0][2:0] win_type;
   typedef logic [2:0][KROW_W-1:0] kernel_type;

   typedef struct packed {
      logic                 emit;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } meta_type;

   typedef struct packed {
      logic     valid;
      meta_type meta;
   } stage_type;

endpackage
`default_nettype wire

[design/c3v_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3v_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module c3v_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[design/c3v_window.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3v_window
// Raster counters, packed line store in RAM and the 3x3 pixel window.
// ----------------------------------------------------------------------------
module c3v_window (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        accept,
   input  c3v_pkg::pix_type            pixel,
   input  logic [c3v_pkg::WREG_W-1:0]  image_width,
   input  logic [c3v_pkg::ROW_W-1:0]   image_height,
   output c3v_pkg::stage_type          stage_out,
   output c3v_pkg::win_type            win
);
   import c3v_pkg::*;

   logic [COL_W-1:0]   col_ff, col_in, cur_col;
   logic [ROW_W-1:0]   row_ff, row_in, cur_row, row_pre, row_next;
   logic [EXT_W-1:0]   eff_w, col_next_ext;
   logic [ROW_W-1:0]   eff_h;
   logic               wrap_pre;
   meta_type           meta_in;

   logic [MAX_WIDTH-1:0] valid_ff;
   logic               s1_valid_ff, s1_hit_ff;
   logic [COL_W-1:0]   s1_col_ff;
   pix_type            s1_px_ff;
   meta_type           s1_meta_ff;
   logic               s2_valid_ff;
   meta_type           s2_meta_ff;
   win_type            win_ff;

   logic [LINE_W-1:0]  rd_data;
   pix_type            older, newer;
   logic               s1_go;

   // Counter step: wrap before the pixel, locate it, then wrap after it.
   always_comb begin
      eff_w = EXT_W'(image_width);
      if (image_width < WREG_W'(MIN_SIZE)) begin
         eff_w = EXT_W'(MIN_SIZE);
      end
      if (EXT_W'(image_width) > EXT_W'(MAX_WIDTH)) begin
         eff_w = EXT_W'(MAX_WIDTH);
      end
      eff_h = (image_height < ROW_W'(MIN_SIZE)) ? ROW_W'(MIN_SIZE) : image_height;

      wrap_pre = EXT_W'(col_ff) >= eff_w;
      cur_col  = wrap_pre ? '0 : col_ff;
      row_pre  = wrap_pre ? row_ff + 1'b1 : row_ff;
      cur_row  = (row_pre >= eff_h) ? '0 : row_pre;

      col_next_ext = EXT_W'(cur_col) + EXT_W'(1);
      row_next     = cur_row + 1'b1;
      if (col_next_ext >= eff_w) begin
         col_in = '0;
         row_in = (row_next >= eff_h) ? '0 : row_next;
      end else begin
         col_in = col_next_ext[COL_W-1:0];
         row_in = cur_row;
      end

      meta_in.emit = (cur_row >= ROW_W'(2)) && (cur_col >= COL_W'(2));
      meta_in.row  = cur_row - ROW_W'(2);
      meta_in.col  = OUT_COL_W'(cur_col - COL_W'(2));
      meta_in.last = (cur_row == eff_h - ROW_W'(1)) &&
                     (EXT_W'(cur_col) == eff_w - EXT_W'(1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (accept) begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Line store: older row in the high half, newer row in the low half.
   assign s1_go = advance && s1_valid_ff;
   assign older = s1_hit_ff ? pix_type'(rd_data[LINE_W-1:PIX_W]) : '0;
   assign newer = s1_hit_ff ? pix_type'(rd_data[PIX_W-1:0]) : '0;

   c3v_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_go),
      .wr_addr (s1_col_ff),
      .wr_data ({newer, s1_px_ff}),
      .rd_en   (accept),
      .rd_addr (cur_col),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         win_ff      <= '0;
      end else begin
         if (s1_go) begin
            valid_ff[s1_col_ff] <= 1'b1;
            for (int r = 0; r < 3; r++) begin
               win_ff[r][0] <= win_ff[r][1];
               win_ff[r][1] <= win_ff[r][2];
            end
            win_ff[0][2] <= older;
            win_ff[1][2] <= newer;
            win_ff[2][2] <= s1_px_ff;
         end
         if (advance) begin
            s1_valid_ff <= accept;
            s2_valid_ff <= s1_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff  <= cur_col;
         s1_px_ff   <= pixel;
         s1_meta_ff <= meta_in;
         s1_hit_ff  <= valid_ff[cur_col];
      end
      if (advance) begin
         s2_meta_ff <= s1_meta_ff;
      end
   end

   assign stage_out.valid = s2_valid_ff;
   assign stage_out.meta  = s2_meta_ff;
   assign win             = win_ff;

endmodule
`default_nettype wire

[design/c3v_mac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3v_mac
// Nine parallel products, row sums, final sum and the result register.
// ----------------------------------------------------------------------------
module c3v_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          advance,
   input  c3v_pkg::stage_type            stage_in,
   input  c3v_pkg::win_type              win,
   input  c3v_pkg::kernel_type           kernel,
   output logic                          rsp_valid,
   output logic signed [c3v_pkg::ACC_W-1:0] conv_value,
   output c3v_pkg::meta_type             rsp_meta
);
   import c3v_pkg::*;

   logic                     p_valid_ff, q_valid_ff, out_valid_ff;
   meta_type                 p_meta_ff, q_meta_ff, out_meta_ff;
   logic signed [PROD_W-1:0] prod_ff [3][3];
   logic signed [ACC_W-1:0]  rsum_ff [3];
   logic signed [ACC_W-1:0]  out_sum_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         q_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         p_valid_ff   <= stage_in.valid && stage_in.meta.emit;
         q_valid_ff   <= p_valid_ff;
         out_valid_ff <= q_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
               prod_ff[r][k] <= $signed(win[r][k]) *
                                $signed(kernel[r][k*WGT_W +: WGT_W]);
            end
            rsum_ff[r] <= ACC_W'(prod_ff[r][0]) + ACC_W'(prod_ff[r][1]) +
                          ACC_W'(prod_ff[r][2]);
         end
         p_meta_ff <= stage_in.meta;
         q_meta_ff <= p_meta_ff;
         if (q_valid_ff) begin
            out_sum_ff  <= rsum_ff[0] + rsum_ff[1] + rsum_ff[2];
            out_meta_ff <= q_meta_ff;
         end
      end
   end

   assign rsp_valid  = out_valid_ff;
   assign conv_value = out_sum_ff;
   assign rsp_meta   = out_meta_ff;

endmodule
`default_nettype wire

[design/conv2d_3x3_valid_stream.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// conv2d_3x3_valid_stream
// Streaming 3x3 valid-region correlation of a raster pixel stream.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  carries one signed Q8.8 pixel per beat, in raster order.
//   rsp_*  carries one result beat per pixel whose 3x3 window lies wholly
//          inside the image: the exact Q14.22 sum of nine products, the
//          valid-region row and column, and tlast on the final result of
//          the image. Border pixels produce no beat.
//   csr_*  writes the kernel rows (0..2), image width (3) and height (4);
//          csr_ready is always high. Write only while the block is idle.
// Throughput: one pixel per cycle while no result is stalled. The packed
//   two-row line store is read when a pixel is accepted and written back
//   by the following stage at a different column, so no interlock is needed.
// Path: pixel -> window s1, s2 -> products, row sums, result -> rsp_tvalid.
// Reset: counters return to row 0, column 0, the window and the line-store
//   valid bits clear, kernel resets to zero and geometry to 64 x 64.
// Stall: while a result waits with rsp_tready low, the whole pipeline holds
//   and req_tready drops; it rises again in the cycle the result is taken.
// ----------------------------------------------------------------------------
module conv2d_3x3_valid_stream (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [c3v_pkg::PIX_W-1:0]          req_tdata,  // [15:0] pixel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [35:0] conv_value, [45:36] out_row, [51:46] out_col, rest zero
   output logic [c3v_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                               rsp_tlast,  // last_of_image
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [c3v_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [c3v_pkg::KROW_W-1:0]         csr_data
);
   import c3v_pkg::*;

   kernel_type          kernel_ff;
   logic [WREG_W-1:0]   width_ff;
   logic [ROW_W-1:0]    height_ff;

   logic                advance, accept;
   stage_type           win_stage;
   win_type             win;
   logic signed [ACC_W-1:0] conv_value;
   meta_type            rsp_meta;

   // Configuration: always ready, unknown indexes drop the beat.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff <= '0;
         width_ff  <= WIDTH_RESET;
         height_ff <= HEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (reg_index_type'(csr_index))
            REG_KERNEL_TOP: begin
               kernel_ff[0] <= csr_data;
            end
            REG_KERNEL_MIDDLE: begin
               kernel_ff[1] <= csr_data;
            end
            REG_KERNEL_BOTTOM: begin
               kernel_ff[2] <= csr_data;
            end
            REG_IMAGE_WIDTH: begin
               width_ff <= csr_data[WREG_W-1:0];
            end
            REG_IMAGE_HEIGHT: begin
               height_ff <= csr_data[ROW_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // Advance every stage unless a finished result is held by the receiver.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;

   c3v_window u_window (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .accept       (accept),
      .pixel        (pix_type'(req_tdata)),
      .image_width  (width_ff),
      .image_height (height_ff),
      .stage_out    (win_stage),
      .win          (win)
   );

   c3v_mac u_mac (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .stage_in   (win_stage),
      .win        (win),
      .kernel     (kernel_ff),
      .rsp_valid  (rsp_tvalid),
      .conv_value (conv_value),
      .rsp_meta   (rsp_meta)
   );

   // Pack the result fields from the lowest bit up, pad to whole bytes.
   assign rsp_tdata = {{(RSP_DATA_W - RSP_FIELD_W){1'b0}},
                       rsp_meta.col, rsp_meta.row, conv_value};
   assign rsp_tlast = rsp_meta.last;

endmodule
`default_nettype wire

[design/c3v_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// c3v_checker
// Port-level checks of the convolution stream, bound to the top level.
// ----------------------------------------------------------------------------
module c3v_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [c3v_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tlast
);
   import c3v_pkg::*;

   // No result survives a reset.
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result beat present after reset");

   // A held result keeps its payload.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("stalled result beat changed");

   // A stalled output freezes the whole pipeline, so no pixel is taken.
   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("pixel accepted while result stalled");

   // Valid-region column never reaches the last two columns; padding is zero.
   a_col_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[51:46] != 6'd62 && rsp_tdata[51:46] != 6'd63 &&
                     rsp_tdata[55:52] == 4'd0)
      else $error("result column or padding out of range");

endmodule

bind conv2d_3x3_valid_stream c3v_checker u_checker (.*);
`default_nettype wire

[bench/conv2d_3x3_valid_stream_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// conv2d_3x3_valid_stream_test
// Self-checking bench for the streaming 3x3 valid-region correlation. A short
// table of directed beats (kernel and pixel extremes, ignored register index)
// runs first, then random images of many geometries, including out-of-range
// sizes and geometry changed part-way through an image. Every result beat is
// checked against a behavioural window model in the bench or a typed-in sum.
// ----------------------------------------------------------------------------
module conv2d_3x3_valid_stream_test;
   import c3v_pkg::*;

   // Index that decodes to no register; writes to it must change nothing.
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = 3'd7;

   localparam int IDLE_PERCENT  = 22;
   localparam int SETTLE_CYCLES = 8;       // pipeline is 5 deep, leave margin
   localparam int SMALL_ITEMS   = 700;
   localparam int TALL_HEIGHT   = 350;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 10;

   typedef struct packed {
      logic [ACC_W-1:0]     conv;
      logic [ROW_W-1:0]     row;
      logic [OUT_COL_W-1:0] col;
      logic                 last;
   } conv_result_type;

   typedef enum logic {
      STEP_WRITE,
      STEP_PIXEL
   } step_kind_type;

   typedef struct packed {
      step_kind_type         kind;
      logic [CSR_IDX_W-1:0]  index;
      logic [KROW_W-1:0]     value;
      logic                  typed;   // sum below is typed in, not predicted
      conv_result_type       sum;
   } directed_step_type;

   // -------------------------------------------------------------------------
   // Block ports. Every input holds a known value from time zero.
   // -------------------------------------------------------------------------
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [PIX_W-1:0]        req_tdata  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tlast;
   logic                    csr_valid  = 1'b0;
   logic                    csr_ready;
   logic [CSR_IDX_W-1:0]    csr_index  = '0;
   logic [KROW_W-1:0]       csr_data   = '0;

   conv2d_3x3_valid_stream dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // -------------------------------------------------------------------------
   // Window model: its own copy of the registers, line stores and counters.
   // -------------------------------------------------------------------------
   logic [KROW_W-1:0] kernel_rows [3];          // top, middle, bottom
   logic [WREG_W-1:0] width_reg  = WIDTH_RESET;
   logic [ROW_W-1:0]  height_reg = HEIGHT_RESET;
   pix_type           older_line [MAX_WIDTH];
   pix_type           newer_line [MAX_WIDTH];
   pix_type           window     [3][3];        // [row][col], col 2 newest
   int unsigned       col_pos    = 0;
   int unsigned       row_pos    = 0;

   conv_result_type   window_sums_due [$];
   int unsigned       mismatch_count = 0;
   int unsigned       cycle_count    = 0;
   logic              steady_flow    = 1'b0;    // suppress idling on both sides

   // Widths beyond the line store clamp to it; tiny sizes are used as 3.
   function automatic int unsigned eff_width();
      if (width_reg < MIN_SIZE)
         return MIN_SIZE;
      if (width_reg > MAX_WIDTH)
         return MAX_WIDTH;
      return width_reg;
   endfunction

   function automatic int unsigned eff_height();
      return (height_reg < MIN_SIZE) ? MIN_SIZE : height_reg;
   endfunction

   // Take one pixel into the model; report whether the window now lies
   // wholly inside the image and, if so, the sum it yields.
   task automatic slide_window(input logic [PIX_W-1:0] px, output bit emits,
                               output conv_result_type res);
      int unsigned w;
      int unsigned h;
      int unsigned c;
      longint      acc;
      w     = eff_width();
      h     = eff_height();
      emits = 1'b0;
      res   = '0;
      // Counters are not cleared on a geometry change: wrap them here.
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
      end
      if (row_pos >= h)
         row_pos = 0;
      c = col_pos;
      for (int r = 0; r < 3; r++) begin
         window[r][0] = window[r][1];
         window[r][1] = window[r][2];
      end
      window[0][2]  = older_line[c];
      window[1][2]  = newer_line[c];
      older_line[c] = newer_line[c];
      newer_line[c] = px;
      window[2][2]  = px;
      if (row_pos >= 2 && c >= 2) begin
         acc = 0;
         for (int k = 0; k < 3; k++)
            for (int r = 0; r < 3; r++)
               acc += longint'(window[r][k]) *
                      longint'($signed(kernel_rows[r][WGT_W*k +: WGT_W]));
         res.conv = acc[ACC_W-1:0];
         res.row  = ROW_W'(row_pos - 2);
         res.col  = OUT_COL_W'(c - 2);
         res.last = (row_pos == h - 1) && (c == w - 1);
         emits    = 1'b1;
      end
      col_pos = c + 1;
      if (col_pos >= w) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= h)
            row_pos = 0;
      end
   endtask

   // -------------------------------------------------------------------------
   // Clock and cycle watchdog.
   // -------------------------------------------------------------------------
   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("conv2d_3x3_valid_stream test failed");
         $finish;
      end
   end

   // -------------------------------------------------------------------------
   // Result side: stall at random, check every accepted beat against the
   // oldest sum due.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin : take_result
      conv_result_type due;
      conv_result_type got;
      logic [RSP_DATA_W-RSP_FIELD_W-1:0] pad;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.conv = rsp_tdata[ACC_W-1:0];
            got.row  = rsp_tdata[ACC_W +: ROW_W];
            got.col  = rsp_tdata[ACC_W+ROW_W +: OUT_COL_W];
            got.last = rsp_tlast;
            pad      = rsp_tdata[RSP_DATA_W-1:RSP_FIELD_W];
            if (window_sums_due.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("cycle %0d: result beat with no sum due: conv %h row %0d col %0d last %b",
                           cycle_count, got.conv, got.row, got.col, got.last);
            end else begin
               due = window_sums_due.pop_front();
               if (got != due || pad != '0) begin
                  mismatch_count++;
                  if (mismatch_count <= REPORT_LIMIT)
                     $display({"cycle %0d: expected conv %h row %0d col %0d last %b, ",
                               "got conv %h row %0d col %0d last %b pad %h"},
                              cycle_count, due.conv, due.row, due.col, due.last,
                              got.conv, got.row, got.col, got.last, pad);
               end
            end
         end
         rsp_tready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // -------------------------------------------------------------------------
   // Drivers. Inputs change only by nonblocking assignment at a rising edge;
   // a handshake is read back just after the edge, before any update lands.
   // -------------------------------------------------------------------------

   // Offer one pixel, idling first at random unless steady_flow is set; predict once it is taken.
   task automatic send_pixel(input logic [PIX_W-1:0] px, input logic typed,
                             input conv_result_type typed_sum);
      bit              emits;
      conv_result_type res;
      if (!steady_flow) begin
         while ($urandom_range(0, 99) < IDLE_PERCENT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      do @(posedge clock); while (!req_tready);
      slide_window(px, emits, res);
      if (typed)
         window_sums_due.push_back(typed_sum);
      else if (emits)
         window_sums_due.push_back(res);
   endtask

   // Leave csr_valid high on return so back-to-back writes need no gap;
   // the caller drops it after the last one.
   task automatic write_register(input logic [CSR_IDX_W-1:0] idx,
                                 input logic [KROW_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         REG_KERNEL_TOP:    kernel_rows[0] = value;
         REG_KERNEL_MIDDLE: kernel_rows[1] = value;
         REG_KERNEL_BOTTOM: kernel_rows[2] = value;
         REG_IMAGE_WIDTH:   width_reg      = value[WREG_W-1:0];
         REG_IMAGE_HEIGHT:  height_reg     = value[ROW_W-1:0];
         default: ;
      endcase
   endtask

   // Drop both valids, drain every sum due, then let border pixels that
   // produce nothing clear the pipeline before the next register write.
   task automatic settle();
      req_tvalid <= 1'b0;
      csr_valid  <= 1'b0;
      while (window_sums_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // -------------------------------------------------------------------------
   // Stimulus.
   // -------------------------------------------------------------------------
   initial begin : stimulus
      directed_step_type directed_steps [$];
      logic [KROW_W-1:0] krow [3];
      logic [KROW_W-1:0] noise;
      logic [WREG_W-1:0] width_code;
      logic [ROW_W-1:0]  height_code;
      logic [PIX_W-1:0]  px;
      logic [WGT_W-1:0]  wgt;
      int unsigned       image_px;
      int unsigned       count;
      int unsigned       small_sent;
      int unsigned       phase;

      foreach (kernel_rows[r])
         kernel_rows[r] = '0;
      foreach (older_line[i]) begin
         older_line[i] = '0;
         newer_line[i] = '0;
      end
      foreach (window[r, k])
         window[r][k] = '0;

      // Directed table. Image 1 is 3 x 3 with a single unit weight on the
      // newest pixel, so only its last pixel yields a sum: pixel * 2^14.
      // Image 2 has every weight and pixel at the most negative code, the
      // largest positive sum there is.
      directed_steps.push_back('{STEP_WRITE, REG_IMAGE_WIDTH, 48'd3, 1'b0, '0});
      directed_steps.push_back('{STEP_WRITE, REG_IMAGE_HEIGHT, 48'd3, 1'b0, '0});
      directed_steps.push_back('{STEP_WRITE, REG_KERNEL_BOTTOM, 48'h4000_0000_0000,
                                 1'b0, '0});
      directed_steps.push_back('{STEP_WRITE, REG_UNUSED, 48'hFFFF_FFFF_FFFF, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'h0000, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'hFFFF, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'h8000, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'h7FFF, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'h0001, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'h00FF, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'h5555, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'hAAAA, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'h7FFF, 1'b1,
                                 '{36'h01FFFC000, 10'd0, 6'd0, 1'b1}});
      directed_steps.push_back('{STEP_WRITE, REG_KERNEL_TOP, 48'h8000_8000_8000, 1'b0, '0});
      directed_steps.push_back('{STEP_WRITE, REG_KERNEL_MIDDLE, 48'h8000_8000_8000,
                                 1'b0, '0});
      directed_steps.push_back('{STEP_WRITE, REG_KERNEL_BOTTOM, 48'h8000_8000_8000,
                                 1'b0, '0});
      for (int i = 0; i < 8; i++)
         directed_steps.push_back('{STEP_PIXEL, '0, 48'h8000, 1'b0, '0});
      directed_steps.push_back('{STEP_PIXEL, '0, 48'h8000, 1'b1,
                                 '{36'h240000000, 10'd0, 6'd0, 1'b1}});

      // Hold reset from time zero, then release it for good.
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_steps[i]) begin
         if (directed_steps[i].kind == STEP_WRITE) begin
            settle();
            write_register(directed_steps[i].index, directed_steps[i].value);
         end else begin
            if (csr_valid)
               csr_valid <= 1'b0;
            send_pixel(directed_steps[i].value[PIX_W-1:0], directed_steps[i].typed,
                       directed_steps[i].sum);
         end
      end

      // Random phases. Phase 0 is one widest, shortest image with no idling;
      // phase 1 one narrowest, tall image. Later phases are small images,
      // some with out-of-range sizes and some stopping part-way through, so
      // the next geometry lands mid-image.
      small_sent = 0;
      for (phase = 0; phase < 2 || small_sent < SMALL_ITEMS; phase++) begin
         settle();
         steady_flow <= (phase == 0) || (phase % 9 == 5);

         if (phase == 0) begin
            width_code  = WREG_W'(MAX_WIDTH);
            height_code = ROW_W'(MIN_SIZE);
         end else if (phase == 1) begin
            width_code  = WREG_W'(MIN_SIZE);
            height_code = ROW_W'(TALL_HEIGHT);
         end else begin
            case ($urandom_range(0, 9))
               0: begin
                  width_code  = WREG_W'($urandom_range(0, 2));
                  height_code = ROW_W'($urandom_range(3, 6));
               end
               1: begin
                  width_code  = WREG_W'($urandom_range(MAX_WIDTH + 1, 127));
                  height_code = ROW_W'($urandom_range(3, 4));
               end
               2: begin
                  width_code  = WREG_W'($urandom_range(3, 8));
                  height_code = ROW_W'($urandom_range(0, 2));
               end
               default: begin
                  width_code  = WREG_W'($urandom_range(3, 12));
                  height_code = ROW_W'($urandom_range(3, 8));
               end
            endcase
         end

         // Weights lean on the extremes so the sum reaches its corners.
         foreach (krow[r]) begin
            for (int k = 0; k < 3; k++) begin
               case ($urandom_range(0, 5))
                  0:       wgt = 16'h7FFF;
                  1:       wgt = 16'h8000;
                  2:       wgt = '0;
                  default: wgt = WGT_W'($urandom());
               endcase
               krow[r][WGT_W*k +: WGT_W] = wgt;
            end
         end
         write_register(REG_KERNEL_TOP, krow[0]);
         write_register(REG_KERNEL_MIDDLE, krow[1]);
         write_register(REG_KERNEL_BOTTOM, krow[2]);
         // Fill unused high bits with noise; the block must mask them.
         noise = KROW_W'({$urandom(), $urandom()});
         write_register(REG_IMAGE_WIDTH, {noise[KROW_W-1:WREG_W], width_code});
         noise = KROW_W'({$urandom(), $urandom()});
         write_register(REG_IMAGE_HEIGHT, {noise[KROW_W-1:ROW_W], height_code});
         if ($urandom_range(0, 7) == 0)
            write_register(REG_UNUSED, KROW_W'({$urandom(), $urandom()}));
         csr_valid <= 1'b0;

         image_px = eff_width() * eff_height();
         if (phase < 2)
            count = image_px;
         else if ($urandom_range(0, 3) == 0)
            count = $urandom_range(1, image_px);
         else
            count = image_px * $urandom_range(1, 2);

         for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
               0:       px = 16'h7FFF;
               1:       px = 16'h8000;
               default: px = PIX_W'($urandom());
            endcase
            send_pixel(px, 1'b0, '0);
         end
         if (phase >= 2)
            small_sent += count;
      end

      // Drain, then give any stray beat time to show up before deciding.
      settle();
      if (mismatch_count == 0 && window_sums_due.size() == 0)
         $display("conv2d_3x3_valid_stream test passed");
      else
         $display("conv2d_3x3_valid_stream test failed");
      $finish;
   end

endmodule

[conv2d_3x3_valid_stream.f]
design/c3v_pkg.sv
design/c3v_ram.sv
design/c3v_window.sv
design/c3v_mac.sv
design/conv2d_3x3_valid_stream.sv
design/c3v_checker.sv
bench/conv2d_3x3_valid_stream_test.sv
